@@ rtl/hxi_pkg.sv @@
// ----------------------------------------------------------------------------
// Hilbert index package
// Shared types, sizes and codes for the Hilbert point-to-index pipeline.
// ----------------------------------------------------------------------------
package hxi_pkg;

    // Grid sizes
    localparam int MAX_ORDER   = 16;
    localparam int COORD_W     = 16;
    localparam int INDEX_W     = 32;
    localparam int ORDER_W     = 5;
    localparam int MODE_W      = 4;
    localparam int LEVEL_W     = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ORDER  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIENT_MODE = 1'd1;

    // Orientation mode codes
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SWAP     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_CW   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_CCW  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_FLIP_Y   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_FLIP_X   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ANTIDIAG = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ROT_180  = 4'd8;

    // One point in flight: the working coordinates and the partial index
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INDEX_W-1:0] d;
    } t_point;

    // Settings shared by every stage while an item is in flight
    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [COORD_W-1:0] mask;
        logic [MODE_W-1:0]  mode;
    } t_ctrl;

endpackage

@@ rtl/hilbert_xy_to_index_unit.sv @@
// ----------------------------------------------------------------------------
// Hilbert point-to-index unit
// Maps a grid point to its position along an oriented Hilbert curve.
// ----------------------------------------------------------------------------
// The unit accepts one point per clock while the chain can advance and returns
// one index per point, in order, through one orientation stage followed
// by a chain of 16 level cells, one per coordinate bit, whose last register
// is the output register. The whole chain advances together whenever the
// output register is empty or its result is being taken, so the sustained
// rate is one point per cycle while the receiver keeps taking results.
// Registers may be written only while no point is in flight.
module hilbert_xy_to_index_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hxi_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hxi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hxi_pkg::COORD_W-1:0]     i_coord_x,
    input  logic [hxi_pkg::COORD_W-1:0]     i_coord_y,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hxi_pkg::INDEX_W-1:0]     o_curve_index
);
    import hxi_pkg::*;

    logic [ORDER_W-1:0]   r_grid_order;
    logic [MODE_W-1:0]    r_orient_mode;
    logic [ORDER_W-1:0]   w_order;
    logic [INDEX_W:0]     w_span;
    logic [INDEX_W-1:0]   w_rev_mask;
    logic                 w_en;
    t_ctrl                w_ctrl;
    logic                 w_valid [MAX_ORDER+1];
    t_point               w_pt    [MAX_ORDER+1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_order  <= ORDER_W'(MAX_ORDER);
            r_orient_mode <= MODE_IDENTITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_ORDER:  r_grid_order  <= i_cfg_data;
                CFG_ORIENT_MODE: r_orient_mode <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective order saturates at the largest supported grid.
    assign w_order = (r_grid_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                           : r_grid_order;
    assign w_ctrl.order = w_order;
    assign w_ctrl.mode  = r_orient_mode;
    assign w_ctrl.mask  = COORD_W'((17'd1 << w_order) - 17'd1);

    // All index bits below twice the order, for the reversed curve.
    assign w_span     = ((INDEX_W+1)'(1) << {w_order, 1'b0}) - (INDEX_W+1)'(1);
    assign w_rev_mask = w_span[INDEX_W-1:0];

    // The chain moves as one whenever the output register can take a result.
    assign w_en       = !w_valid[MAX_ORDER] || i_out_ready;
    assign o_in_ready = w_en;

    hxi_orient u_orient (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_ctrl    (w_ctrl),
        .o_valid   (w_valid[0]),
        .o_pt      (w_pt[0])
    );

    // One cell per bit level, top bit first.
    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        hxi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_level (LEVEL_W'(MAX_ORDER - 1 - k)),
            .i_ctrl  (w_ctrl),
            .i_valid (w_valid[k]),
            .i_pt    (w_pt[k]),
            .o_valid (w_valid[k+1]),
            .o_pt    (w_pt[k+1])
        );
    end

    // Reversal is N*N-1-d, which inside the index span is a bitwise invert.
    assign o_out_valid   = w_valid[MAX_ORDER];
    assign o_curve_index = (r_orient_mode == MODE_REVERSE) ?
                           (w_pt[MAX_ORDER].d ^ w_rev_mask) : w_pt[MAX_ORDER].d;

endmodule

@@ rtl/hxi_orient.sv @@
// ----------------------------------------------------------------------------
// Hilbert orientation stage
// Masks the point to the grid and applies the selected symmetry, registered.
// ----------------------------------------------------------------------------
module hxi_orient (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [hxi_pkg::COORD_W-1:0] i_coord_x,
    input  logic [hxi_pkg::COORD_W-1:0] i_coord_y,
    input  hxi_pkg::t_ctrl         i_ctrl,
    output logic                   o_valid,
    output hxi_pkg::t_point        o_pt
);
    import hxi_pkg::*;

    logic               r_valid;
    t_point             r_pt;
    t_point             n_pt;
    logic [COORD_W-1:0] w_x;
    logic [COORD_W-1:0] w_y;
    logic [COORD_W-1:0] w_nx;
    logic [COORD_W-1:0] w_ny;

    // Masked coordinates and their mirror images (m - v equals m ^ v here).
    assign w_x  = i_coord_x & i_ctrl.mask;
    assign w_y  = i_coord_y & i_ctrl.mask;
    assign w_nx = w_x ^ i_ctrl.mask;
    assign w_ny = w_y ^ i_ctrl.mask;

    // Symmetry selection; unknown codes walk the point unchanged.
    always_comb begin
        n_pt   = '0;
        n_pt.x = w_x;
        n_pt.y = w_y;
        unique case (i_ctrl.mode)
            MODE_SWAP: begin
                n_pt.x = w_y;
                n_pt.y = w_x;
            end
            MODE_ROT_CW: begin
                n_pt.x = w_ny;
                n_pt.y = w_x;
            end
            MODE_ROT_CCW: begin
                n_pt.x = w_y;
                n_pt.y = w_nx;
            end
            MODE_FLIP_Y: begin
                n_pt.y = w_ny;
            end
            MODE_FLIP_X: begin
                n_pt.x = w_nx;
            end
            MODE_ANTIDIAG: begin
                n_pt.x = w_ny;
                n_pt.y = w_nx;
            end
            MODE_ROT_180: begin
                n_pt.x = w_nx;
                n_pt.y = w_ny;
            end
            default: begin
            end
        endcase
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt <= n_pt;
        end
    end

    assign o_valid = r_valid;
    assign o_pt    = r_pt;

endmodule

@@ rtl/hxi_cell.sv @@
// ----------------------------------------------------------------------------
// Hilbert level cell
// Resolves one bit level of the quadrant walk and hands the point onward.
// ----------------------------------------------------------------------------
module hxi_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [hxi_pkg::LEVEL_W-1:0] i_level,
    input  hxi_pkg::t_ctrl              i_ctrl,
    input  logic                        i_valid,
    input  hxi_pkg::t_point             i_pt,
    output logic                        o_valid,
    output hxi_pkg::t_point             o_pt
);
    import hxi_pkg::*;

    logic         r_valid;
    t_point       r_pt;
    t_point       n_pt;
    logic         w_active;
    logic         w_rx;
    logic         w_ry;
    logic [1:0]   w_code;

    // A level at or above the grid order leaves the point untouched.
    assign w_active = ({1'b0, i_level} < i_ctrl.order);
    assign w_rx     = i_pt.x[i_level];
    assign w_ry     = i_pt.y[i_level];
    assign w_code   = {w_rx, w_rx ^ w_ry};

    // Quadrant contribution and rotate or flip of the sub-square.
    always_comb begin
        n_pt = i_pt;
        if (w_active) begin
            n_pt.d = i_pt.d | (INDEX_W'(w_code) << {i_level, 1'b0});
            if (!w_ry) begin
                if (w_rx) begin
                    n_pt.x = i_pt.y ^ i_ctrl.mask;
                    n_pt.y = i_pt.x ^ i_ctrl.mask;
                end else begin
                    n_pt.x = i_pt.y;
                    n_pt.y = i_pt.x;
                end
            end
        end
    end

    // Cell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt <= n_pt;
        end
    end

    assign o_valid = r_valid;
    assign o_pt    = r_pt;

endmodule

@@ rtl/hxi_checker.sv @@
// ----------------------------------------------------------------------------
// Hilbert unit checker
// Port-level assertions on flow control of the point-to-index unit.
// ----------------------------------------------------------------------------
module hxi_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [hxi_pkg::INDEX_W-1:0] o_curve_index
);
    import hxi_pkg::*;

    // An empty output register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    // A result being taken frees a slot for a new point in the same cycle.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output is being drained");

    // The first cycle after reset shows no result.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

    // A stalled result keeps its value until transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_curve_index))
        else $error("stalled result changed or dropped");

endmodule

bind hilbert_xy_to_index_unit hxi_checker u_hxi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_curve_index (o_curve_index)
);

@@ bench/hilbert_xy_to_index_unit_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hilbert point-to-index checker
// Watches the configuration port and both streaming channels of the unit. It
// keeps its own copy of the registers, works out the curve index of every
// accepted point and compares each result transfer with the oldest index
// still owed by the unit.
// ----------------------------------------------------------------------------
module hilbert_xy_to_index_unit_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hxi_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hxi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [hxi_pkg::COORD_W-1:0]     i_coord_x,
    input  logic [hxi_pkg::COORD_W-1:0]     i_coord_y,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [hxi_pkg::INDEX_W-1:0]     i_curve_index,
    input  logic                            i_run_done,
    output int                              o_fail_count,
    output int                              o_pending
);
    import hxi_pkg::*;

    // Only the first few mismatches are printed; all of them are counted.
    localparam int MAX_REPORTS = 50;

    logic [ORDER_W-1:0] grid_order_q;
    logic [MODE_W-1:0]  orient_mode_q;
    logic [INDEX_W-1:0] owed_index_q[$];
    logic               done_seen;
    logic [INDEX_W-1:0] oldest_index;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        done_seen     = 1'b0;
        grid_order_q  = 5'd16;
        orient_mode_q = MODE_IDENTITY;
    end

    task automatic report_mismatch(input string what);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    // Bit-serial quadrant walk on a grid of side m+1, from the top level down.
    function automatic logic [63:0] hilbert_walk(input int unsigned order,
                                                 input logic [63:0] m,
                                                 input logic [63:0] x_in,
                                                 input logic [63:0] y_in);
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] y;
        int unsigned lvl;
        d = 64'd0;
        x = x_in;
        y = y_in;
        for (lvl = order; lvl > 0; lvl--) begin
            s  = 64'd1 << (lvl - 1);
            rx = ((x & s) != 64'd0) ? 64'd1 : 64'd0;
            ry = ((y & s) != 64'd0) ? 64'd1 : 64'd0;
            d  = d + s * s * ((64'd3 * rx) ^ ry);
            if (ry == 64'd0) begin
                if (rx == 64'd1) begin
                    x = m - x;
                    y = m - y;
                end
                t = x;
                x = y;
                y = t;
            end
        end
        return d;
    endfunction

    // Orientation transform, then the walk, under the current register copy.
    function automatic logic [INDEX_W-1:0] oriented_index(input logic [COORD_W-1:0] cx,
                                                          input logic [COORD_W-1:0] cy);
        int unsigned order;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] d;
        order = grid_order_q;
        if (order > MAX_ORDER) begin
            order = MAX_ORDER;
        end
        m = (64'd1 << order) - 64'd1;
        x = {48'd0, cx} & m;
        y = {48'd0, cy} & m;
        case (orient_mode_q)
            MODE_SWAP:     d = hilbert_walk(order, m, y, x);
            MODE_REVERSE:  d = (m + 64'd1) * (m + 64'd1) - 64'd1 - hilbert_walk(order, m, x, y);
            MODE_ROT_CW:   d = hilbert_walk(order, m, m - y, x);
            MODE_ROT_CCW:  d = hilbert_walk(order, m, y, m - x);
            MODE_FLIP_Y:   d = hilbert_walk(order, m, x, m - y);
            MODE_FLIP_X:   d = hilbert_walk(order, m, m - x, y);
            MODE_ANTIDIAG: d = hilbert_walk(order, m, m - y, m - x);
            MODE_ROT_180:  d = hilbert_walk(order, m, m - x, m - y);
            default:       d = hilbert_walk(order, m, x, y);
        endcase
        return d[INDEX_W-1:0];
    endfunction

    // Results are compared before new points are queued; a register write
    // takes effect for points accepted after its edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_order_q  = 5'd16;
            orient_mode_q = MODE_IDENTITY;
            owed_index_q.delete();
        end else begin
            // Result transfer
            if (i_out_valid && i_out_ready) begin
                if (owed_index_q.size() == 0) begin
                    report_mismatch($sformatf("result %08h with no point in flight",
                                              i_curve_index));
                end else begin
                    oldest_index = owed_index_q.pop_front();
                    if (i_curve_index !== oldest_index) begin
                        report_mismatch($sformatf("curve_index got %08h, expected %08h",
                                                  i_curve_index, oldest_index));
                    end
                end
            end

            // Point transfer
            if (i_in_valid && i_in_ready) begin
                owed_index_q.push_back(oriented_index(i_coord_x, i_coord_y));
            end

            // Register write
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_GRID_ORDER) begin
                    grid_order_q = i_cfg_data[ORDER_W-1:0];
                end else if (i_cfg_index == CFG_ORIENT_MODE) begin
                    orient_mode_q = i_cfg_data[MODE_W-1:0];
                end
            end

            // Anything still owed at the end of the run is a failure.
            if (i_run_done && !done_seen) begin
                done_seen = 1'b1;
                if (owed_index_q.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              owed_index_q.size()));
                end
            end
        end
        o_pending = owed_index_q.size();
    end

endmodule

@@ bench/hilbert_xy_to_index_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hilbert point-to-index unit test
// Drives points into the unit under a series of grid orders and orientation
// modes, with random gaps on the sender and random stalls on the receiver,
// and lets the checker compare every result. Gives the final verdict.
// ----------------------------------------------------------------------------
module hilbert_xy_to_index_unit_test;
    import hxi_pkg::*;

    localparam int RANDOM_ITEMS = 880;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;

    // Mode codes above the last named one act as identity.
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_TOP = 4'd15;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = CFG_GRID_ORDER;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic [COORD_W-1:0]     i_coord_x     = '0;
    logic [COORD_W-1:0]     i_coord_y     = '0;
    logic                   i_out_ready   = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [INDEX_W-1:0]     o_curve_index;

    logic run_done    = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_served = 1'b0;
    logic no_idle     = 1'b0;
    int   fail_count;
    int   pending;
    int   hold_left   = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;

    hilbert_xy_to_index_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_curve_index (o_curve_index)
    );

    hilbert_xy_to_index_unit_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_curve_index (o_curve_index),
        .i_run_done    (run_done),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Coordinate: corners, single bits and plain random values.
    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end else if (r == 2) begin
            return COORD_W'(1) << $urandom_range(0, COORD_W - 1);
        end
        return COORD_W'($urandom_range(0, 65535));
    endfunction

    // Receiver: random stalls, one long hold-off on request, or none at all.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= pick_gap();
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing is transferred for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one point after an optional gap and hold it until its transfer.
    // Called and left at a falling edge.
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input int gap);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_coord_x  = x;
        i_coord_y  = y;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] order,
                            input logic [CFG_DATA_W-1:0] mode);
        wait_idle();
        write_reg(CFG_GRID_ORDER, order);
        write_reg(CFG_ORIENT_MODE, mode);
    endtask

    initial begin
        int sent;
        int phase;
        int count;
        int r;
        logic [CFG_DATA_W-1:0] order;
        logic [CFG_DATA_W-1:0] mode;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: full 16-bit grid, identity orientation.
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'hFFFF, 16'hFFFF, 0);
        send_point(16'hFFFF, 16'h0000, 0);
        send_point(16'h0000, 16'hFFFF, 0);
        send_point(16'h8000, 16'h0001, 1);
        send_point(16'hAAAA, 16'h5555, 0);

        // Order zero: a single cell, index zero even when reversed.
        set_grid(5'd0, {1'b0, MODE_REVERSE});
        send_point(16'hFFFF, 16'hFFFF, 0);
        send_point(16'h1234, 16'h0000, 0);

        // Order above the maximum saturates.
        set_grid(5'd31, {1'b0, MODE_ROT_180});
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'hFFFF, 16'h0000, 0);

        // Reversal on the full grid reaches the top index.
        set_grid(5'd16, {1'b0, MODE_REVERSE});
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'hFFFF, 16'h0000, 0);

        // Smallest real grid with an unknown mode, which acts as identity.
        set_grid(5'd1, {1'b1, MODE_UNKNOWN_TOP});
        send_point(16'h0001, 16'h0000, 0);
        send_point(16'h0001, 16'h0001, 0);
        send_point(16'hFFFE, 16'hFFFF, 0);

        // Upper data bit of the mode register is dropped.
        set_grid(5'd17, {1'b1, MODE_ROT_CW});
        send_point(16'h0007, 16'h0009, 0);

        // Random phases: every mode code in turn first, then random ones.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                order = 5'd0;
            end else if (r == 1) begin
                order = 5'd1;
            end else if (r == 2) begin
                order = 5'd16;
            end else if (r == 3) begin
                order = 5'd31;
            end else if (r < 7) begin
                order = CFG_DATA_W'($urandom_range(2, 6));
            end else begin
                order = CFG_DATA_W'($urandom_range(0, 31));
            end
            if (phase < 16) begin
                mode = {1'($urandom_range(0, 1)), MODE_W'(phase)};
            end else begin
                mode = CFG_DATA_W'($urandom_range(0, 31));
            end
            set_grid(order, mode);

            // One phase fills the pipeline against a long receiver hold-off,
            // others run with no idling on either side.
            hold_req = (phase == 2);
            no_idle  = (phase % 7 == 4);
            count    = hold_req ? 80 : $urandom_range(20, 60);
            repeat (count) begin
                send_point(pick_coord(), pick_coord(),
                           (hold_req || no_idle) ? 0 : pick_gap());
                sent = sent + 1;
            end
            hold_req = 1'b0;
            no_idle  = 1'b0;
            phase    = phase + 1;
        end

        // Let the last results drain, then settle the verdict.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        run_done = 1'b1;
        repeat (2) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
